### hw/rtl/bfra_pkg.sv
package bfra_pkg;

	localparam int unsigned UNIT_W = 24;

	localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_NO_FIT     = 3'd1,
		STAT_ZERO_FREE  = 3'd2,
		STAT_OUT_RANGE  = 3'd3,
		STAT_TABLE_FULL = 3'd4
	} status_t;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// One free-table entry as stored in memory.
	typedef struct packed {
		logic              valid;
		logic [UNIT_W-1:0] start;
		logic [UNIT_W-1:0] size;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Running results of one pass over the table.
	typedef struct packed {
		logic              fit_found;
		logic [UNIT_W-1:0] fit_start;
		logic [UNIT_W-1:0] fit_size;
		logic [UNIT_W-1:0] max1;
		logic              max_multi;
		logic [UNIT_W-1:0] max2;
		logic              nxt_found;
		logic [UNIT_W-1:0] nxt_size;
		logic              prv_found;
		logic [UNIT_W-1:0] prv_start;
		logic [UNIT_W-1:0] prv_size;
		logic              slot_found;
	} scan_sum_t;

endpackage

### hw/rtl/bfra_if.sv
interface bfra_req_if;
	import bfra_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [UNIT_W-1:0] start_offset;
	logic [UNIT_W-1:0] unit_count;

	modport source (output valid, action, start_offset, unit_count, input ready);
	modport sink   (input valid, action, start_offset, unit_count, output ready);
endinterface

interface bfra_rsp_if;
	import bfra_pkg::*;
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] granted_offset;
	logic [2:0]        status;
	logic [UNIT_W-1:0] largest_free;
	logic [UNIT_W-1:0] used_units;

	modport source (output valid, granted_offset, status, largest_free, used_units,
		input ready);
	modport sink   (input valid, granted_offset, status, largest_free, used_units,
		output ready);
endinterface

### hw/rtl/best_fit_range_allocator_core.sv
// Best-fit range allocator with coalescing. The free table (FREE_RANGES
// entries of start, size and valid) lives in one synchronous RAM. Every
// request transaction reads the whole table once, one entry per cycle,
// then writes back at most two entries and presents one response
// transaction. The scan ends once the read pipe has drained. A free
// that merges with ranges on both sides needs a second write (ST_WR2).
// The next request can be accepted in the same cycle as the response is
// presented. The scan is bound by the single RAM read port. The block
// holds in completion while an earlier response still waits for the
// sink. After reset and after every capacity write, a clearing pass over
// every entry rebuilds the table as one range [0, capacity); no request
// is accepted during that pass. A new request is accepted while the
// previous response still waits for the sink. Capacity must only be
// written while the block is idle.
module best_fit_range_allocator_core import bfra_pkg::*; #(
	parameter int unsigned FREE_RANGES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [UNIT_W-1:0] wr_data,
	bfra_req_if.sink          req,
	bfra_rsp_if.source        rsp
);

	localparam int unsigned IW = $clog2(FREE_RANGES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WR1,
		ST_WR2,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [UNIT_W-1:0] cap_q;
	logic [UNIT_W-1:0] used_q;
	logic [IW-1:0]     clr_q;
	logic [IW:0]       rd_q;
	logic              dv_s1;
	logic [IW-1:0]     idx_s1;

	// latched request
	logic              act_q;
	logic [UNIT_W-1:0] off_q;
	logic [UNIT_W-1:0] units_q;

	// pending response and deferred second write
	logic [UNIT_W-1:0] res_grant_q;
	status_t           res_stat_q;
	logic [UNIT_W-1:0] res_large_q;
	logic [IW-1:0]     wr2_idx_q;
	entry_t            wr2_ent_q;

	logic              out_valid_q;
	logic [UNIT_W-1:0] out_grant_q;
	status_t           out_stat_q;
	logic [UNIT_W-1:0] out_large_q;
	logic [UNIT_W-1:0] out_used_q;

	scan_sum_t     sum;
	logic [IW-1:0] fit_idx, nxt_idx, prv_idx, slot_idx;
	entry_t        rd_ent;
	logic [ENTRY_W-1:0] rd_raw;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;

	logic          scan_clr;

	// write-back decision, evaluated in ST_WR1
	status_t           d_stat;
	logic [UNIT_W-1:0] d_grant;
	logic [UNIT_W-1:0] d_large;
	logic [UNIT_W-1:0] d_used;
	logic              d_we1;
	logic [IW-1:0]     d_idx1;
	entry_t            d_ent1;
	logic              d_we2;
	logic [UNIT_W:0]   end_pos;
	logic [UNIT_W-1:0] new_size;
	logic [UNIT_W+1:0] merged_w;
	logic [UNIT_W-1:0] merged;
	logic [UNIT_W-1:0] rest_large;
	logic [UNIT_W:0]   used_add;
	entry_t            merged_ent;

	assign rd_ent   = entry_t'(rd_raw);
	assign mem_re   = (state_q == ST_SCAN) && (rd_q < (IW+1)'(FREE_RANGES));
	assign scan_clr = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !wr_en;

	bfra_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FREE_RANGES)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_q[IW-1:0]),
		.rdata (rd_raw)
	);

	bfra_scan #(
		.IW (IW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (scan_clr),
		.dv       (dv_s1),
		.idx      (idx_s1),
		.ent      (rd_ent),
		.offset   (off_q),
		.units    (units_q),
		.sum      (sum),
		.fit_idx  (fit_idx),
		.nxt_idx  (nxt_idx),
		.prv_idx  (prv_idx),
		.slot_idx (slot_idx)
	);

	// Decide status, result and table writes from the completed scan.
	always_comb begin
		end_pos    = {1'b0, off_q} + {1'b0, units_q};
		new_size   = sum.fit_size - units_q;
		merged_w   = {2'b00, units_q}
			+ (sum.nxt_found ? {2'b00, sum.nxt_size} : '0)
			+ (sum.prv_found ? {2'b00, sum.prv_size} : '0);
		merged     = (merged_w > {2'b00, UNIT_MAX}) ? UNIT_MAX : merged_w[UNIT_W-1:0];
		used_add   = {1'b0, used_q} + {1'b0, units_q};
		rest_large = (sum.max2 > new_size) ? sum.max2 : new_size;

		merged_ent.valid = 1'b1;
		merged_ent.start = sum.prv_found ? sum.prv_start : off_q;
		merged_ent.size  = merged;

		d_stat  = STAT_OK;
		d_grant = '0;
		d_large = sum.max1;
		d_used  = used_q;
		d_we1   = 1'b0;
		d_idx1  = fit_idx;
		d_ent1  = '0;
		d_we2   = 1'b0;

		if (act_q == ACT_ALLOC) begin
			if (units_q == '0 || !sum.fit_found) begin
				d_stat = STAT_NO_FIT;
			end else begin
				d_grant = sum.fit_start;
				d_we1   = 1'b1;
				if (sum.fit_size > units_q) begin
					d_ent1.valid = 1'b1;
					d_ent1.start = sum.fit_start + units_q;
					d_ent1.size  = new_size;
				end
				d_used = used_add[UNIT_W] ? UNIT_MAX : used_add[UNIT_W-1:0];
				// the picked range is the smallest fit, so it can only lower
				// the maximum when it alone holds that maximum
				if (sum.fit_size < sum.max1 || sum.max_multi) begin
					d_large = sum.max1;
				end else begin
					d_large = rest_large;
				end
			end
		end else begin
			if (units_q == '0) begin
				d_stat = STAT_ZERO_FREE;
			end else if (end_pos > {1'b0, cap_q}) begin
				d_stat = STAT_OUT_RANGE;
			end else if (!sum.nxt_found && !sum.prv_found && !sum.slot_found) begin
				d_stat = STAT_TABLE_FULL;
			end else begin
				d_we1 = 1'b1;
				d_used = (used_q > units_q) ? (used_q - units_q) : '0;
				// merged range covers any range it absorbs
				d_large = (merged > sum.max1) ? merged : sum.max1;
				if (sum.nxt_found && sum.prv_found) begin
					d_idx1 = nxt_idx;
					d_ent1 = '0;
					d_we2  = 1'b1;
				end else begin
					d_idx1 = sum.prv_found ? prv_idx :
						(sum.nxt_found ? nxt_idx : slot_idx);
					d_ent1 = merged_ent;
				end
			end
		end
	end

	// Drive the single write port: clearing pass or write-back.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == '0 && cap_q != '0) begin
					mem_wdata.valid = 1'b1;
					mem_wdata.size  = cap_q;
				end
			end
			ST_WR1: begin
				mem_we    = d_we1;
				mem_waddr = d_idx1;
				mem_wdata = d_ent1;
			end
			ST_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = wr2_idx_q;
				mem_wdata = wr2_ent_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cap_q       <= UNIT_MAX;
			used_q      <= '0;
			clr_q       <= '0;
			rd_q        <= '0;
			dv_s1       <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			dv_s1  <= mem_re;
			idx_s1 <= rd_q[IW-1:0];
			// load a new response or drop the one just taken by the sink
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				// capacity write restarts the table from scratch
				cap_q   <= wr_data;
				used_q  <= '0;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == IW'(FREE_RANGES - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (scan_clr) begin
							act_q   <= req.action;
							off_q   <= req.start_offset;
							units_q <= req.unit_count;
							rd_q    <= '0;
							state_q <= ST_SCAN;
						end
					end
					ST_SCAN: begin
						if (mem_re) begin
							rd_q <= rd_q + 1'b1;
						end else if (!dv_s1) begin
							// last entry has been folded into the scan results
							state_q <= ST_WR1;
						end
					end
					ST_WR1: begin
						res_grant_q <= d_grant;
						res_stat_q  <= d_stat;
						res_large_q <= d_large;
						used_q      <= d_used;
						wr2_idx_q   <= prv_idx;
						wr2_ent_q   <= merged_ent;
						state_q     <= d_we2 ? ST_WR2 : ST_DONE;
					end
					ST_WR2: begin
						state_q <= ST_DONE;
					end
					ST_DONE: begin
						// hold until the output register is free
						if (!out_valid_q || rsp.ready) begin
							out_grant_q <= res_grant_q;
							out_stat_q  <= res_stat_q;
							out_large_q <= res_large_q;
							out_used_q  <= used_q;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_offset = out_grant_q;
	assign rsp.status         = out_stat_q;
	assign rsp.largest_free   = out_large_q;
	assign rsp.used_units     = out_used_q;

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("table written during scan");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside completion");

	a_used_update: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> ($past(state_q == ST_WR1) || $past(wr_en)))
		else $error("used units changed outside write-back");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= (IW+1)'(FREE_RANGES))
		else $error("scan address overran table");

endmodule

### hw/rtl/bfra_ram.sv
module bfra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/bfra_scan.sv
module bfra_scan import bfra_pkg::*; #(
	parameter int unsigned IW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              dv,
	input  logic [IW-1:0]     idx,
	input  entry_t            ent,
	input  logic [UNIT_W-1:0] offset,
	input  logic [UNIT_W-1:0] units,
	output scan_sum_t         sum,
	output logic [IW-1:0]     fit_idx,
	output logic [IW-1:0]     nxt_idx,
	output logic [IW-1:0]     prv_idx,
	output logic [IW-1:0]     slot_idx
);

	scan_sum_t sum_q;
	logic [IW-1:0] fit_idx_q, nxt_idx_q, prv_idx_q, slot_idx_q;

	logic [UNIT_W:0] end_pos;
	logic [UNIT_W:0] ent_end;
	logic take_fit, hit_nxt, hit_prv;

	assign end_pos = {1'b0, offset} + {1'b0, units};
	assign ent_end = {1'b0, ent.start} + {1'b0, ent.size};

	always_comb begin
		take_fit = ent.valid && (ent.size >= units) && (!sum_q.fit_found ||
			(ent.size < sum_q.fit_size) ||
			(ent.size == sum_q.fit_size && ent.start < sum_q.fit_start));
		hit_nxt = ent.valid && !sum_q.nxt_found && ({1'b0, ent.start} == end_pos);
		hit_prv = ent.valid && !hit_nxt && !sum_q.prv_found &&
			(ent_end == {1'b0, offset});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			fit_idx_q  <= '0;
			nxt_idx_q  <= '0;
			prv_idx_q  <= '0;
			slot_idx_q <= '0;
		end else if (clr) begin
			sum_q <= '0;
		end else if (dv) begin
			if (take_fit) begin
				sum_q.fit_found <= 1'b1;
				sum_q.fit_start <= ent.start;
				sum_q.fit_size  <= ent.size;
				fit_idx_q       <= idx;
			end
			// keep the largest size, whether it repeats, and the runner-up
			if (ent.valid) begin
				if (ent.size > sum_q.max1) begin
					sum_q.max2      <= sum_q.max1;
					sum_q.max1      <= ent.size;
					sum_q.max_multi <= 1'b0;
				end else if (ent.size == sum_q.max1) begin
					sum_q.max_multi <= 1'b1;
				end else if (ent.size > sum_q.max2) begin
					sum_q.max2 <= ent.size;
				end
			end
			if (hit_nxt) begin
				sum_q.nxt_found <= 1'b1;
				sum_q.nxt_size  <= ent.size;
				nxt_idx_q       <= idx;
			end
			if (hit_prv) begin
				sum_q.prv_found <= 1'b1;
				sum_q.prv_start <= ent.start;
				sum_q.prv_size  <= ent.size;
				prv_idx_q       <= idx;
			end
			if (!ent.valid && !sum_q.slot_found) begin
				sum_q.slot_found <= 1'b1;
				slot_idx_q       <= idx;
			end
		end
	end

	assign sum      = sum_q;
	assign fit_idx  = fit_idx_q;
	assign nxt_idx  = nxt_idx_q;
	assign prv_idx  = prv_idx_q;
	assign slot_idx = slot_idx_q;

endmodule
